// ----- rtl/dq_pkg.sv -----
package dq_pkg;

	// storage geometry (DEPTH must be a power of two for the ring wrap)
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CMD_W      = 3;
	localparam int STAT_W     = 2;

	// packed stream widths, rounded up to whole bytes
	localparam int IN_BITS  = CMD_W + DATA_WIDTH;
	localparam int OUT_BITS = DATA_WIDTH + STAT_W + CNT_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// command codes; the two top codes are no-ops
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} dq_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture input word, read the addressed end
		logic exec;   // apply the command, load the result register
	} dp_cmd_t;

endpackage

// ----- rtl/dq_ctrl.sv -----
module dq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output dq_pkg::dp_cmd_t  dp_cmd
);
	import dq_pkg::*;

	dq_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		dp_cmd.load = 1'b0;
		dp_cmd.exec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					dp_cmd.load = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				dp_cmd.exec = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				m_tvalid = 1'b1;
				// a new word may enter as the result leaves
				s_tready = m_tready;
				if (m_tready) begin
					if (s_tvalid) begin
						dp_cmd.load = 1'b1;
						state_d     = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/dq_datapath.sv -----
module dq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dq_pkg::dp_cmd_t                  dp_cmd,
	input  logic [dq_pkg::CMD_W-1:0]         command,
	input  logic signed [dq_pkg::DATA_WIDTH-1:0] value,
	output logic signed [dq_pkg::DATA_WIDTH-1:0] data,
	output logic [dq_pkg::STAT_W-1:0]        status,
	output logic [dq_pkg::CNT_W-1:0]         count
);
	import dq_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [ADDR_W-1:0]     head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  we;
	logic [ADDR_W-1:0]     wa;
	logic [DATA_WIDTH-1:0] res_data;
	status_t               res_status;
	logic                  empty, full;
	logic [DATA_WIDTH-1:0] data_q;
	status_t               status_q;
	logic [CNT_W-1:0]      count_q;

	// front-side commands read at head, others at tail
	assign rd_addr = (cmd_code_t'(command) == CMD_PUSH_FRONT ||
		cmd_code_t'(command) == CMD_POP_FRONT ||
		cmd_code_t'(command) == CMD_PEEK_FRONT) ? head_q : tail_q;

	// ring store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= val_q;
		end
		if (dp_cmd.load) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// captured command word
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q <= command;
			val_q <= value;
		end
	end

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));

	// command decode and pointer update
	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		cnt_d      = cnt_q;
		we         = 1'b0;
		wa         = head_q;
		res_data   = '0;
		res_status = ST_OK;
		unique case (cmd_code_t'(cmd_q))
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) begin
					res_status = ST_OVER;
				end else begin
					// store only on the execute step
					we       = dp_cmd.exec;
					res_data = val_q;
					cnt_d    = cnt_q + CNT_W'(1);
					if (empty) begin
						tail_d = head_q;
						wa     = head_q;
					end else if (cmd_code_t'(cmd_q) == CMD_PUSH_FRONT) begin
						head_d = head_q - ADDR_W'(1);
						wa     = head_d;
					end else begin
						tail_d = tail_q + ADDR_W'(1);
						wa     = tail_d;
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (empty) begin
					res_status = ST_UNDER;
				end else begin
					res_data = rd_data_q;
					cnt_d    = cnt_q - CNT_W'(1);
					// last entry leaves both indices in place
					if (cnt_q != CNT_W'(1)) begin
						if (cmd_code_t'(cmd_q) == CMD_POP_FRONT) begin
							head_d = head_q + ADDR_W'(1);
						end else begin
							tail_d = tail_q - ADDR_W'(1);
						end
					end
				end
			end
			CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (empty) begin
					res_status = ST_UNDER;
				end else begin
					res_data = rd_data_q;
				end
			end
			default: ;
		endcase
	end

	// control state: indices and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (dp_cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			data_q   <= res_data;
			status_q <= res_status;
			count_q  <= cnt_d;
		end
	end

	assign data   = data_q;
	assign status = status_q;
	assign count  = count_q;

`ifndef SYNTHESIS
	// fill count never passes capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("deque count above capacity");

	// with at most one entry both ends coincide
	a_ends_meet: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(1) |-> head_q == tail_q)
		else $error("head and tail differ with one or no entry");

	// state moves only on an execute step
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!dp_cmd.exec |=> $stable(cnt_q) && $stable(head_q) && $stable(tail_q))
		else $error("deque state changed outside execute");
`endif

endmodule

// ----- rtl/double_ended_queue.sv -----
// Channel  Dir  Width  Contents (low bit up)
// s_*      in   40     command[2:0], value[34:3], zero pad
// m_*      out  40     data[31:0], status[33:32], count[38:34], zero pad
//
// Each word passes through a capture step that also reads the ring store
// at the addressed end, then an execute step that updates indices and
// loads the result register; the result is then held until it is accepted.
// A new word is taken in the cycle the pending result is accepted.
// Reset (arst_n low) empties the deque; stored words are not cleared.
module double_ended_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [dq_pkg::IN_W-1:0]   s_tdata,  // command, value
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [dq_pkg::OUT_W-1:0]  m_tdata   // data, status, count
);
	import dq_pkg::*;

	dp_cmd_t                       dp_cmd;
	logic signed [DATA_WIDTH-1:0]  data;
	logic [STAT_W-1:0]             status;
	logic [CNT_W-1:0]              count;

	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_cmd   (dp_cmd)
	);

	dq_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.dp_cmd  (dp_cmd),
		.command (s_tdata[CMD_W-1:0]),
		.value   (s_tdata[CMD_W+DATA_WIDTH-1:CMD_W]),
		.data    (data),
		.status  (status),
		.count   (count)
	);

	// pack result word
	assign m_tdata = {{(OUT_W-OUT_BITS){1'b0}}, count, status, data};

endmodule

// ----- dv/double_ended_queue_test.sv -----
`timescale 1ns / 100ps

module double_ended_queue_test;
	import dq_pkg::*;

	// codes 6 and 7 decode to no-ops in the block
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	localparam int PHASE_SLOW_SINK   = 0;
	localparam int PHASE_SLOW_SOURCE = 1;
	localparam int PHASE_FULL_RATE   = 2;

	localparam int RANDOM_PER_PHASE = 133;
	localparam int HOLD_CYCLES      = 64;
	localparam int TAIL_CYCLES      = 20;
	localparam int CYCLE_LIMIT      = 300000;

	typedef struct {
		logic [CMD_W-1:0]             cmd;
		logic signed [DATA_WIDTH-1:0] value;
		int                           phase;
		bit                           drain_first;  // wait until all results are back
		bit                           hold_sink;    // start a long sink hold-off
	} deque_cmd_t;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] data;
		logic [STAT_W-1:0]            status;
		logic [CNT_W-1:0]             count;
	} deque_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;   // command, value
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // data, status, count

	deque_cmd_t    command_backlog[$];
	deque_result_t awaited_results[$];
	deque_cmd_t    offered_cmd;
	int            run_phase = PHASE_SLOW_SINK;
	logic          hold_req = 1'b0;
	int            hold_left = 0;
	int            error_count = 0;
	int            cycle_count = 0;

	// shadow deque
	logic signed [DATA_WIDTH-1:0] shadow_store[DEPTH];
	logic [ADDR_W-1:0]            front_idx = '0;
	logic [ADDR_W-1:0]            back_idx = '0;
	logic [CNT_W-1:0]             held = '0;

	double_ended_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int idle_pct(input int phase, input bit sink_side);
		case (phase)
			PHASE_SLOW_SINK:   return sink_side ? 75 : 30;
			PHASE_SLOW_SOURCE: return sink_side ? 30 : 75;
			default:           return 0;
		endcase
	endfunction

	// apply one command to the shadow deque and queue the result it yields
	task automatic apply_command(input deque_cmd_t c);
		deque_result_t r;
		bit            at_front;
		r.data = '0;
		r.status = ST_OK;
		case (c.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (held == DEPTH) begin
					r.status = ST_OVER;
				end else begin
					if (held == 0) begin
						back_idx = front_idx;
						shadow_store[front_idx] = c.value;
					end else if (c.cmd == CMD_PUSH_FRONT) begin
						front_idx = front_idx - 1'b1;
						shadow_store[front_idx] = c.value;
					end else begin
						back_idx = back_idx + 1'b1;
						shadow_store[back_idx] = c.value;
					end
					held = held + 1'b1;
					r.data = c.value;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (held == 0) begin
					r.status = ST_UNDER;
				end else begin
					at_front = (c.cmd == CMD_POP_FRONT) || (c.cmd == CMD_PEEK_FRONT);
					r.data = at_front ? shadow_store[front_idx] : shadow_store[back_idx];
					if (c.cmd == CMD_POP_FRONT || c.cmd == CMD_POP_BACK) begin
						// popping the last entry leaves both indices in place
						if (held > 1) begin
							if (at_front)
								front_idx = front_idx + 1'b1;
							else
								back_idx = back_idx - 1'b1;
						end
						held = held - 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.count = held;
		awaited_results.push_back(r);
	endtask

	task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [DATA_WIDTH-1:0] value,
			input int phase);
		deque_cmd_t c;
		c.cmd = cmd;
		c.value = value;
		c.phase = phase;
		c.drain_first = 1'b0;
		c.hold_sink = 1'b0;
		command_backlog.push_back(c);
	endtask

	function automatic logic [DATA_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
			1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
			2:       return '0;
			3:       return '1;
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// a run of pushes or of pops, each with some peeks mixed in, or unstructured noise
	task automatic add_segment(input int phase, inout int added);
		int               kind;
		int               len;
		logic [CMD_W-1:0] c;
		kind = $urandom_range(0, 99);
		len = $urandom_range(3, 20);
		for (int i = 0; i < len; i++) begin
			if (kind < 40) begin
				if ($urandom_range(0, 4) == 0)
					c = $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
				else
					c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			end else if (kind < 75) begin
				if ($urandom_range(0, 4) == 0)
					c = $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
				else
					c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
			end else begin
				c = CMD_W'($urandom_range(0, 7));
			end
			add_item(c, pick_value(), phase);
			if (c != CMD_SPARE_6 && c != CMD_SPARE_7)
				added++;
		end
	endtask

	// source: offers backlog words, predicts on each accepted word
	always @(posedge clk or negedge arst_n) begin : source_drv
		bit taken;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			hold_req <= 1'b0;
		end else begin
			taken = s_tvalid && s_tready;
			if (taken)
				apply_command(offered_cmd);
			hold_req <= taken && offered_cmd.hold_sink;
			if (s_tvalid && !taken) begin
				// word still on offer, leave it alone
			end else if (command_backlog.size() != 0
					&& !(command_backlog[0].drain_first && awaited_results.size() != 0)
					&& $urandom_range(0, 99) >= idle_pct(command_backlog[0].phase, 1'b0)) begin
				offered_cmd = command_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= IN_W'({offered_cmd.value, offered_cmd.cmd});
				run_phase <= offered_cmd.phase;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long sink hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// sink: checks each accepted result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : sink_mon
		deque_result_t                want;
		logic signed [DATA_WIDTH-1:0] got_data;
		logic [STAT_W-1:0]            got_status;
		logic [CNT_W-1:0]             got_count;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_data = m_tdata[DATA_WIDTH-1:0];
				got_status = m_tdata[DATA_WIDTH +: STAT_W];
				got_count = m_tdata[DATA_WIDTH+STAT_W +: CNT_W];
				if (awaited_results.size() == 0) begin
					flag_error($sformatf("unexpected word data=%0d status=%0d count=%0d",
						got_data, got_status, got_count));
				end else begin
					want = awaited_results.pop_front();
					if (got_data !== want.data)
						flag_error($sformatf("data %0d, expected %0d", got_data, want.data));
					if (got_status !== want.status)
						flag_error($sformatf("status %0d, expected %0d", got_status, want.status));
					if (got_count !== want.count)
						flag_error($sformatf("count %0d, expected %0d", got_count, want.count));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(run_phase, 1'b1));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("double_ended_queue verification failed");
			$finish;
		end
	end

	initial begin
		int added;

		// directed: empty cases, extremes, last-entry pops, push into empty
		add_item(CMD_POP_FRONT, '0, PHASE_SLOW_SINK);
		add_item(CMD_POP_BACK, '1, PHASE_SLOW_SINK);
		add_item(CMD_PEEK_FRONT, '0, PHASE_SLOW_SINK);
		add_item(CMD_PEEK_BACK, '1, PHASE_SLOW_SINK);
		add_item(CMD_SPARE_6, 32'h1234_5678, PHASE_SLOW_SINK);
		add_item(CMD_SPARE_7, '1, PHASE_SLOW_SINK);
		add_item(CMD_PUSH_FRONT, 32'h7fff_ffff, PHASE_SLOW_SINK);
		add_item(CMD_PUSH_FRONT, 32'h8000_0000, PHASE_SLOW_SINK);
		add_item(CMD_PUSH_BACK, 32'hffff_ffff, PHASE_SLOW_SINK);
		add_item(CMD_PUSH_BACK, 32'h0000_0000, PHASE_SLOW_SINK);
		add_item(CMD_PEEK_FRONT, '0, PHASE_SLOW_SINK);
		add_item(CMD_PEEK_BACK, '0, PHASE_SLOW_SINK);
		add_item(CMD_SPARE_6, '0, PHASE_SLOW_SINK);
		add_item(CMD_POP_BACK, '0, PHASE_SLOW_SINK);
		add_item(CMD_POP_FRONT, '0, PHASE_SLOW_SINK);
		add_item(CMD_POP_BACK, '0, PHASE_SLOW_SINK);
		add_item(CMD_POP_FRONT, '0, PHASE_SLOW_SINK);
		add_item(CMD_PEEK_BACK, '0, PHASE_SLOW_SINK);
		add_item(CMD_PUSH_BACK, 32'h5a5a_5a5a, PHASE_SLOW_SINK);
		add_item(CMD_PEEK_FRONT, '0, PHASE_SLOW_SINK);
		add_item(CMD_POP_BACK, '0, PHASE_SLOW_SINK);
		add_item(CMD_PUSH_FRONT, 32'ha5a5_a5a5, PHASE_SLOW_SINK);
		add_item(CMD_POP_FRONT, '0, PHASE_SLOW_SINK);

		// random runs, one batch per phase
		for (int p = PHASE_SLOW_SINK; p <= PHASE_FULL_RATE; p++) begin
			added = 0;
			while (added < RANDOM_PER_PHASE) begin
				add_segment(p, added);
				if (p == PHASE_SLOW_SOURCE && added < 20)
					command_backlog[command_backlog.size()-1].drain_first = 1'b1;
				if (p == PHASE_FULL_RATE && added >= 40 && added < 60)
					command_backlog[command_backlog.size()-1].hold_sink = 1'b1;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (command_backlog.size() != 0 || s_tvalid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("double_ended_queue verification clean");
		else
			$display("double_ended_queue verification failed");
		$finish;
	end

endmodule
